// File: rtl/core/pvpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpm_pkg
// Shared types and constants of the pyramid view pixel mapper.
// ----------------------------------------------------------------------------
package pvpm_pkg;

  // Largest addressable frame dimension.
  localparam int unsigned MAX_DIM = 2048;

  // Signed width for intermediate coordinates. It covers every sum of the
  // 12-bit sizes and MAX_DIM.
  localparam int unsigned CoordW = 16;

  localparam int unsigned DimW  = 12;
  localparam int unsigned PosW  = 11;
  localparam int unsigned ChanW = 8;

  // Configuration register indexes.
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;

  // View codes, equal to the quarter turns applied.
  localparam logic [1:0] ViewBottom = 2'd0;
  localparam logic [1:0] ViewLeft   = 2'd1;
  localparam logic [1:0] ViewTop    = 2'd2;
  localparam logic [1:0] ViewRight  = 2'd3;

  typedef struct packed {
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
  } pvpm_cfg_t;

  // One classified pixel, as it waits between front and back.
  typedef struct packed {
    logic [1:0]               view_index;
    logic                     mask_ok;
    logic signed [CoordW-1:0] turned_row;
    logic signed [CoordW-1:0] turned_col;
    logic [ChanW-1:0]         red;
    logic [ChanW-1:0]         green;
    logic [ChanW-1:0]         blue;
  } pvpm_item_t;

endpackage

// File: rtl/core/pvpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpm_front
// Classifies an incoming pixel: mask test, frame test in the turned frame,
// and the turned position.
// ----------------------------------------------------------------------------
module pvpm_front import pvpm_pkg::*; (
  input  pvpm_cfg_t        cfg_i,
  input  logic [1:0]       view_index_i,
  input  logic [PosW-1:0]  src_row_i,
  input  logic [PosW-1:0]  src_col_i,
  input  logic [DimW-1:0]  view_width_i,
  input  logic [DimW-1:0]  view_height_i,
  input  logic [ChanW-1:0] red_in_i,
  input  logic [ChanW-1:0] green_in_i,
  input  logic [ChanW-1:0] blue_in_i,
  output pvpm_item_t       item_o
);

  // Halving that truncates toward zero.
  function automatic logic signed [CoordW-1:0] half_tz(input logic signed [CoordW-1:0] v);
    logic signed [CoordW-1:0] adj;
    adj = v + {{(CoordW-1){1'b0}}, v[CoordW-1]};
    return adj >>> 1;
  endfunction

  logic signed [CoordW-1:0] fw, fh, ow, oh, iw, ih, y, x;
  logic signed [CoordW-1:0] x_pad, y_pad, i_pad_raw, i_pad, r, c;
  logic                     in_mask, in_frame;

  always_comb begin
    fw = $signed({{(CoordW-DimW){1'b0}}, cfg_i.frame_width});
    fh = $signed({{(CoordW-DimW){1'b0}}, cfg_i.frame_height});
    iw = $signed({{(CoordW-DimW){1'b0}}, view_width_i});
    ih = $signed({{(CoordW-DimW){1'b0}}, view_height_i});
    y  = $signed({{(CoordW-PosW){1'b0}}, src_row_i});
    x  = $signed({{(CoordW-PosW){1'b0}}, src_col_i});

    // Odd views see the frame turned on its side.
    ow = view_index_i[0] ? fh : fw;
    oh = view_index_i[0] ? fw : fh;

    x_pad     = half_tz(ow - iw);
    y_pad     = half_tz(oh) - ih;
    i_pad_raw = half_tz(iw) - y_pad - y;
    i_pad     = i_pad_raw[CoordW-1] ? '0 : i_pad_raw;

    r = oh - ih + y;
    c = x + x_pad;

    in_mask  = (y < ih) && (x >= i_pad) && (x < iw - i_pad);
    in_frame = (r >= 0) && (r < oh) && (c >= 0) && (c < ow);

    item_o.view_index = view_index_i;
    item_o.mask_ok    = in_mask && in_frame;
    item_o.turned_row = r;
    item_o.turned_col = c;
    item_o.red        = red_in_i;
    item_o.green      = green_in_i;
    item_o.blue       = blue_in_i;
  end

endmodule

// File: rtl/core/pvpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpm_queue
// Two-entry FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module pvpm_queue import pvpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pvpm_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output pvpm_item_t pop_item_o
);

  pvpm_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/core/pvpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpm_back
// Turns a classified pixel back into frame coordinates, checks the
// addressable range and registers the result word.
// ----------------------------------------------------------------------------
module pvpm_back import pvpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pvpm_cfg_t        cfg_i,
  input  logic             item_valid_i,
  input  pvpm_item_t       item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  output logic             write_enable_o,
  output logic [PosW-1:0]  dest_row_o,
  output logic [PosW-1:0]  dest_col_o,
  output logic [ChanW-1:0] red_out_o,
  output logic [ChanW-1:0] green_out_o,
  output logic [ChanW-1:0] blue_out_o
);

  localparam logic signed [CoordW-1:0] MaxDimS = CoordW'(MAX_DIM);
  localparam logic signed [CoordW-1:0] OneS    = CoordW'(1);

  logic signed [CoordW-1:0] fw, fh, r, c, row, col;
  logic                     ok;

  logic             out_valid_q;
  logic             we_q, we_d;
  logic [PosW-1:0]  row_q, row_d, col_q, col_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  // The receiver never stalls, so a waiting word always drains.
  assign item_pop_o = item_valid_i;

  always_comb begin
    fw = $signed({{(CoordW-DimW){1'b0}}, cfg_i.frame_width});
    fh = $signed({{(CoordW-DimW){1'b0}}, cfg_i.frame_height});
    r  = item_i.turned_row;
    c  = item_i.turned_col;
    case (item_i.view_index)
      ViewBottom: begin
        row = r;
        col = c;
      end
      ViewLeft: begin
        row = c;
        col = fw - OneS - r;
      end
      ViewTop: begin
        row = fh - OneS - r;
        col = fw - OneS - c;
      end
      ViewRight: begin
        row = fh - OneS - c;
        col = r;
      end
      default: begin
        row = r;
        col = c;
      end
    endcase
    ok = item_i.mask_ok && (row >= 0) && (col >= 0) && (row < MaxDimS) && (col < MaxDimS);
    we_d  = ok;
    row_d = ok ? row[PosW-1:0] : '0;
    col_d = ok ? col[PosW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      we_q    <= we_d;
      row_q   <= row_d;
      col_q   <= col_d;
      red_q   <= item_i.red;
      green_q <= item_i.green;
      blue_q  <= item_i.blue;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign dest_row_o     = row_q;
  assign dest_col_o     = col_q;
  assign red_out_o      = red_q;
  assign green_out_o    = green_q;
  assign blue_out_o     = blue_q;

endmodule

// File: rtl/core/pyramid_view_pixel_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyramid_view_pixel_mapper_top
// Maps pixels of four pyramid source views into one output frame.
//
// Channel   Direction  Handshake                       Word
// pixel     in         start && !busy                  view, position, size, rgb
// config    in         cfg_valid_i && cfg_ready_o      index, 12-bit value
// result    out        out_valid_o strobe, one cycle   write enable, row, col, rgb
//
// One pixel per clock. An accepted pixel is classified by the front stage and
// written into the two-entry queue; the back stage then rotates it and
// registers the result, which is presented from that register.
// Reset leaves the frame at 1024 x 1024 with the queue empty.
// The receiver cannot stall, so the queue never fills and busy stays low.
// ----------------------------------------------------------------------------
module pyramid_view_pixel_mapper_top import pvpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       view_index_i,
  input  logic [PosW-1:0]  src_row_i,
  input  logic [PosW-1:0]  src_col_i,
  input  logic [DimW-1:0]  view_width_i,
  input  logic [DimW-1:0]  view_height_i,
  input  logic [ChanW-1:0] red_in_i,
  input  logic [ChanW-1:0] green_in_i,
  input  logic [ChanW-1:0] blue_in_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [DimW-1:0]  cfg_data_i,
  output logic             out_valid_o,
  output logic             write_enable_o,
  output logic [PosW-1:0]  dest_row_o,
  output logic [PosW-1:0]  dest_col_o,
  output logic [ChanW-1:0] red_out_o,
  output logic [ChanW-1:0] green_out_o,
  output logic [ChanW-1:0] blue_out_o
);

  pvpm_cfg_t  cfg_q, cfg_d;
  pvpm_item_t front_item, queue_item;
  logic       queue_full, queue_empty, queue_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFrameWidth:  cfg_d.frame_width  = cfg_data_i;
        RegFrameHeight: cfg_d.frame_height = cfg_data_i;
        default: ;  // other indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= DimW'(1024);
      cfg_q.frame_height <= DimW'(1024);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy = queue_full;

  pvpm_front u_front (
    .cfg_i         (cfg_q),
    .view_index_i  (view_index_i),
    .src_row_i     (src_row_i),
    .src_col_i     (src_col_i),
    .view_width_i  (view_width_i),
    .view_height_i (view_height_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .item_o        (front_item)
  );

  pvpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_item_o  (queue_item)
  );

  pvpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (!queue_empty),
    .item_i         (queue_item),
    .item_pop_o     (queue_pop),
    .out_valid_o    (out_valid_o),
    .write_enable_o (write_enable_o),
    .dest_row_o     (dest_row_o),
    .dest_col_o     (dest_col_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o)
  );

endmodule
